/* hw/rtl/two_d_breakpoint_table_lookup_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-dimensional breakpoint table lookup
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_D_BREAKPOINT_TABLE_LOOKUP_TOP_DEFINES_SVH
`define TWO_D_BREAKPOINT_TABLE_LOOKUP_TOP_DEFINES_SVH

// Assertion that is switched off while reset is applied.
`define TDBL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds through reset.
`define TDBL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tdbl_pkg.sv */
// ----------------------------------------------------------------------------
// Two-dimensional breakpoint table lookup package
// Shared widths, function codes, register indexes and payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdbl_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_WR_ROW  = 2'd0,
        FUNC_WR_COL  = 2'd1,
        FUNC_WR_CELL = 2'd2,
        FUNC_LOOKUP  = 2'd3
    } t_func;

    typedef enum logic {
        CFG_ROWS_IN_USE = 1'b0,
        CFG_COLS_IN_USE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_func                     func;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [DATA_W-1:0]  write_value;
        logic signed [DATA_W-1:0]  row_key;
        logic signed [DATA_W-1:0]  col_key;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  cell_value;
        logic                      hit;
        logic [IDX_W-1:0]          row_found;
        logic [IDX_W-1:0]          col_found;
    } t_out_item;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic                      valid;
        logic                      found;
        logic signed [DATA_W-1:0]  key;
    } t_tok;

endpackage

/* hw/rtl/two_d_breakpoint_table_lookup_top.sv */
// ----------------------------------------------------------------------------
// Two-dimensional breakpoint table lookup
// Usage:
//   Items enter on i_item, transferred at a clock edge with start high and
//   busy low. Codes 0 to 2 write a row breakpoint, a column breakpoint or a
//   table cell; they take effect at that edge, give no result and leave busy
//   low. Code 3 is a lookup and gives one result on o_result, shown for one
//   cycle with o_done; there is no way to hold it off.
//   A lookup token walks one breakpoint cell per cycle down a row chain and a
//   column chain side by side, then the cell table is read once. Each outcome
//   is held until both chains have delivered, the cell read is registered,
//   and the result transfers in the state after that read. The next item can
//   be taken in the same cycle as the result, and no lookup is taken before.
//   The register port (i_cfg_we, i_cfg_index, i_cfg_wdata) sets the rows and
//   columns in use; the user must have it written only while the block is idle,
//   which the block does not enforce. Reset returns the control to idle and
//   both counts to one; breakpoints and cells hold no reset value and must be
//   written before use.
`timescale 1ns / 1ps

module two_d_breakpoint_table_lookup_top #(
    parameter int MAX_ROWS = tdbl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tdbl_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tdbl_pkg::t_in_item            i_item,
    output logic                          o_done,
    output tdbl_pkg::t_out_item           o_result,
    input  logic                          i_cfg_we,
    input  tdbl_pkg::t_cfg_index          i_cfg_index,
    input  logic [tdbl_pkg::CNT_W-1:0]    i_cfg_wdata
);
    import tdbl_pkg::*;

    localparam int RIW       = $clog2(MAX_ROWS);
    localparam int CIW       = $clog2(MAX_COLS);
    localparam int TBL_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW        = $clog2(TBL_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_READ   = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_rows_in_use;
    logic [CNT_W-1:0]         r_cols_in_use;
    logic                     r_row_done;
    logic                     r_col_done;
    logic                     r_row_hit;
    logic                     r_col_hit;
    logic [RIW-1:0]           r_row_idx;
    logic [CIW-1:0]           r_col_idx;
    logic signed [DATA_W-1:0] r_table [TBL_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    logic                     accept;
    logic                     lookup_go;
    logic                     wr_row;
    logic                     wr_col;
    logic                     wr_cell;
    logic                     wr_in_range;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic                     hit;
    t_tok                     row_tok_in;
    t_tok                     col_tok_in;
    t_tok                     row_tok_out;
    t_tok                     col_tok_out;
    logic [RIW-1:0]           row_idx_out;
    logic [CIW-1:0]           col_idx_out;

    assign busy      = !((r_state == ST_IDLE) || (r_state == ST_DONE));
    assign accept    = start && !busy;
    assign lookup_go = accept && (i_item.func == FUNC_LOOKUP);
    assign wr_row    = accept && (i_item.func == FUNC_WR_ROW);
    assign wr_col    = accept && (i_item.func == FUNC_WR_COL);
    assign wr_cell   = accept && (i_item.func == FUNC_WR_CELL);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CNT_W'(1);
            r_cols_in_use <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_wdata;
                CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_wdata;
                default:         r_rows_in_use <= r_rows_in_use;
            endcase
        end
    end

    always_comb begin
        row_tok_in       = '0;
        row_tok_in.valid = lookup_go;
        row_tok_in.key   = i_item.row_key;
        col_tok_in       = '0;
        col_tok_in.valid = lookup_go;
        col_tok_in.key   = i_item.col_key;
    end

    tdbl_chain #(
        .DEPTH (MAX_ROWS)
    ) u_row_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_row),
        .i_wr_addr  (i_item.row_index),
        .i_wr_value (i_item.write_value),
        .i_count    (r_rows_in_use),
        .i_tok      (row_tok_in),
        .o_tok      (row_tok_out),
        .o_idx      (row_idx_out)
    );

    tdbl_chain #(
        .DEPTH (MAX_COLS)
    ) u_col_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_col),
        .i_wr_addr  (i_item.col_index),
        .i_wr_value (i_item.write_value),
        .i_count    (r_cols_in_use),
        .i_tok      (col_tok_in),
        .o_tok      (col_tok_out),
        .o_idx      (col_idx_out)
    );

    // The two chains may differ in length, so each outcome is held until
    // both have arrived.
    always_ff @(posedge i_clk) begin
        if (row_tok_out.valid) begin
            r_row_hit <= row_tok_out.found;
            r_row_idx <= row_idx_out;
        end
        if (col_tok_out.valid) begin
            r_col_hit <= col_tok_out.found;
            r_col_idx <= col_idx_out;
        end
        if (!i_rst_n || lookup_go) begin
            r_row_done <= 1'b0;
            r_col_done <= 1'b0;
        end else begin
            if (row_tok_out.valid) begin
                r_row_done <= 1'b1;
            end
            if (col_tok_out.valid) begin
                r_col_done <= 1'b1;
            end
        end
    end

    // Cell table.
    assign wr_in_range = (int'(i_item.row_index) < MAX_ROWS)
                      && (int'(i_item.col_index) < MAX_COLS);
    assign wr_addr     = AW'(int'(i_item.row_index) * MAX_COLS + int'(i_item.col_index));
    assign rd_addr     = AW'(int'(r_row_idx) * MAX_COLS + int'(r_col_idx));

    always_ff @(posedge i_clk) begin
        if (wr_cell && wr_in_range) begin
            r_table[wr_addr] <= i_item.write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (lookup_go) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_row_done && r_col_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = lookup_go ? ST_SEARCH : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A miss reports zero in every field.
    assign hit                 = r_row_hit && r_col_hit;
    assign o_done              = (r_state == ST_DONE);
    assign o_result.cell_value = hit ? r_rd_data : '0;
    assign o_result.hit        = hit;
    assign o_result.row_found  = hit ? IDX_W'(32'(r_row_idx)) : '0;
    assign o_result.col_found  = hit ? IDX_W'(32'(r_col_idx)) : '0;

endmodule

/* hw/rtl/tdbl_cell.sv */
// ----------------------------------------------------------------------------
// Breakpoint cell
// Holds one breakpoint and tests a passing search token against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdbl_cell #(
    parameter int  DEPTH = tdbl_pkg::MAX_ROWS_DEF,
    parameter int  POS   = 0,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [tdbl_pkg::IDX_W-1:0]          i_wr_addr,
    input  logic signed [tdbl_pkg::DATA_W-1:0]  i_wr_value,
    input  logic [tdbl_pkg::CNT_W-1:0]          i_count,
    input  tdbl_pkg::t_tok                      i_tok,
    input  logic [IW-1:0]                       i_idx,
    output tdbl_pkg::t_tok                      o_tok,
    output logic [IW-1:0]                       o_idx
);
    import tdbl_pkg::*;

    logic signed [DATA_W-1:0] r_bp;
    t_tok                     r_tok;
    logic [IW-1:0]            r_idx;
    t_tok                     n_tok;
    logic [IW-1:0]            n_idx;
    logic                     in_use;
    logic                     match;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_addr) == POS)) begin
            r_bp <= i_wr_value;
        end
    end

    // Only the first count positions take part in the search.
    assign in_use = int'(i_count) > POS;
    assign match  = in_use && !i_tok.found && (i_tok.key >= r_bp);

    always_comb begin
        n_tok       = i_tok;
        n_tok.found = i_tok.found | match;
        n_idx       = match ? IW'(POS) : i_idx;
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

/* hw/rtl/tdbl_chain.sv */
// ----------------------------------------------------------------------------
// Breakpoint chain
// A row of breakpoint cells; a token leaves the last cell with the first
// qualifying position on the axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdbl_chain #(
    parameter int  DEPTH = tdbl_pkg::MAX_ROWS_DEF,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [tdbl_pkg::IDX_W-1:0]          i_wr_addr,
    input  logic signed [tdbl_pkg::DATA_W-1:0]  i_wr_value,
    input  logic [tdbl_pkg::CNT_W-1:0]          i_count,
    input  tdbl_pkg::t_tok                      i_tok,
    output tdbl_pkg::t_tok                      o_tok,
    output logic [IW-1:0]                       o_idx
);
    import tdbl_pkg::*;

    t_tok          tok [DEPTH+1];
    logic [IW-1:0] idx [DEPTH+1];

    assign tok[0] = i_tok;
    assign idx[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tdbl_cell #(
            .DEPTH (DEPTH),
            .POS   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (i_wr_en),
            .i_wr_addr  (i_wr_addr),
            .i_wr_value (i_wr_value),
            .i_count    (i_count),
            .i_tok      (tok[g]),
            .i_idx      (idx[g]),
            .o_tok      (tok[g+1]),
            .o_idx      (idx[g+1])
        );
    end

    assign o_tok = tok[DEPTH];
    assign o_idx = idx[DEPTH];

endmodule

/* hw/rtl/tdbl_checker.sv */
// ----------------------------------------------------------------------------
// Port checker for the two-dimensional breakpoint table lookup
// Watches the top-level ports and is attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_d_breakpoint_table_lookup_top_defines.svh"

module tdbl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  tdbl_pkg::t_in_item            i_item,
    input  logic                          o_done,
    input  tdbl_pkg::t_out_item           o_result,
    input  logic                          i_cfg_we,
    input  tdbl_pkg::t_cfg_index          i_cfg_index,
    input  logic [tdbl_pkg::CNT_W-1:0]    i_cfg_wdata
);
    import tdbl_pkg::*;

    logic lookup_in;
    logic write_in;
    logic cfg_seen;

    assign lookup_in = start && !busy && (i_item.func == FUNC_LOOKUP);
    assign write_in  = start && !busy && (i_item.func != FUNC_LOOKUP);
    // Configuration traffic is not checked here beyond being observed.
    assign cfg_seen  = i_cfg_we && ((i_cfg_index == CFG_ROWS_IN_USE)
                                 || (i_cfg_index == CFG_COLS_IN_USE)
                                 || (i_cfg_wdata != '0) || (i_cfg_wdata == '0));

    `TDBL_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_done, "result strobe after reset")

    `TDBL_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "result strobe held longer than one cycle")

    `TDBL_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_done && !o_result.hit) |-> ((o_result.cell_value == '0) && (o_result.row_found == '0) && (o_result.col_found == '0)), "miss result carries nonzero fields")

    `TDBL_ASSERT(a_lookup_busy, i_clk, i_rst_n, lookup_in |=> (busy && !o_done), "lookup transfer did not start a search")

    `TDBL_ASSERT(a_write_idle, i_clk, i_rst_n, (write_in && !cfg_seen) |=> (!busy && !o_done), "write transfer disturbed the idle state")

endmodule

bind two_d_breakpoint_table_lookup_top tdbl_checker u_tdbl_checker (.*);
